// ===== src/dgpc_pkg.sv =====
// Shared types and constants of the dual-gain pixel calibrator.
package dgpc_pkg;

   localparam int PIX_IN_W       = 11;
   localparam int SAMPLE_W       = 12;
   localparam int COEF_W         = 16;
   localparam int CAL_W          = 17;
   localparam int SLICE_NUM_W    = 5;
   localparam int THR_W          = 12;
   localparam int PED_FRAC       = 4;
   localparam int PROD_W         = CAL_W + COEF_W + 1;
   localparam int FRAC_SHIFT     = COEF_W;

   localparam int SLICES_DEFAULT = 32;
   localparam int PIXELS_DEFAULT = 2048;

   localparam logic [THR_W-1:0] THR_RESET = 12'hFFF;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_SLICE = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [PIX_IN_W-1:0]    pixel_index;
      logic [SAMPLE_W-1:0]    high_sample;
      logic [SAMPLE_W-1:0]    low_sample;
      logic                   last_slice;
      logic [COEF_W-1:0]      ped_high;
      logic [COEF_W-1:0]      ped_low;
      logic [COEF_W-1:0]      gain_high;
      logic [COEF_W-1:0]      gain_low;
   } req_type;

   typedef struct packed {
      logic signed [CAL_W-1:0] calibrated_value;
      logic                    used_high_gain;
      logic [SLICE_NUM_W-1:0]  slice_number;
      logic                    last_result;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] ped_high;
      logic [COEF_W-1:0] ped_low;
      logic [COEF_W-1:0] gain_high;
      logic [COEF_W-1:0] gain_low;
   } coef_type;

   typedef struct packed {
      logic                   capture;
      logic                   coef_write;
      logic                   coef_read;
      logic                   coef_latch;
      logic                   use_high;
      logic                   buf_write;
      logic [SLICE_NUM_W-1:0] buf_index;
      logic                   rd_valid;
      logic [SLICE_NUM_W-1:0] rd_index;
      logic                   rd_last;
   } cmd_type;

   typedef struct packed {
      logic is_slice;
      logic is_last;
      logic high_below;
   } status_type;

endpackage

// ===== src/dual_gain_pixel_calibrator.sv =====
// Top level of the dual-gain pixel calibrator.
//
// A word is taken at a clock edge with start high and busy low. A coefficient
// load or a slice that does not end a pixel keeps busy high through the states
// RED1, RED2 and EXEC, so no new word enters until they are done; these states
// serve the index reduction and the single coefficient table port. A last slice
// keeps busy high through RED1, RED2, EXEC and COEF and then through EMIT, which
// makes one buffer read per cycle, one per buffered slice. Results leave one per
// cycle, each on rsp_data for exactly one cycle with rsp_valid high, after the buffer
// read, product and result registers; the receiver cannot stall them and must take every word.
// The threshold register accepts a write in any cycle (csr_ready stays high).
module dual_gain_pixel_calibrator #(
   parameter int SLICES = dgpc_pkg::SLICES_DEFAULT,
   parameter int PIXELS = dgpc_pkg::PIXELS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  dgpc_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output dgpc_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dgpc_pkg::THR_W-1:0]   csr_data
);
   import dgpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   dgpc_ctrl #(
      .SLICES (SLICES)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dgpc_dp #(
      .SLICES (SLICES),
      .PIXELS (PIXELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/dgpc_ctrl.sv =====
// Controller state machine of the dual-gain pixel calibrator.
module dgpc_ctrl #(
   parameter int SLICES = dgpc_pkg::SLICES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dgpc_pkg::status_type   status,
   output dgpc_pkg::cmd_type      cmd
);
   import dgpc_pkg::*;

   localparam int CNT_W = $clog2(SLICES + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RED1 = 3'd1;
   localparam logic [2:0] S_RED2 = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_COEF = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             flag_ff, flag_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      k_in     = k_ff;
      flag_in  = flag_ff;
      cmd      = '0;
      cmd.use_high  = flag_ff;
      cmd.buf_index = SLICE_NUM_W'(count_ff);
      cmd.rd_index  = SLICE_NUM_W'(k_ff);
      cmd.rd_last   = (k_ff + CNT_W'(1)) == count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_RED1;
            end
         end
         S_RED1: state_in = S_RED2;
         S_RED2: state_in = S_EXEC;
         S_EXEC: begin
            if (status.is_slice) begin
               // drop slices past the buffer depth
               if (count_ff < CNT_W'(SLICES)) begin
                  cmd.buf_write = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  if (!status.high_below) flag_in = 1'b0;
               end
               if (status.is_last) begin
                  cmd.coef_read = 1'b1;
                  state_in      = S_COEF;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.coef_write = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_COEF: begin
            cmd.coef_latch = 1'b1;
            k_in           = '0;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            cmd.rd_valid = 1'b1;
            if (cmd.rd_last) begin
               count_in = '0;
               flag_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         k_ff     <= '0;
         flag_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

// ===== src/dgpc_dp.sv =====
// Datapath of the dual-gain pixel calibrator: tables, buffers and arithmetic.
module dgpc_dp #(
   parameter int SLICES = dgpc_pkg::SLICES_DEFAULT,
   parameter int PIXELS = dgpc_pkg::PIXELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dgpc_pkg::req_type             req_data,
   input  logic                          csr_valid,
   input  logic [dgpc_pkg::THR_W-1:0]    csr_data,
   input  dgpc_pkg::cmd_type             cmd,
   output dgpc_pkg::status_type          status,
   output logic                          rsp_valid,
   output dgpc_pkg::rsp_type             rsp_data
);
   import dgpc_pkg::*;

   localparam int PIX_LOG   = $clog2(PIXELS);
   localparam int PIX_AW    = (PIX_LOG > 0) ? PIX_LOG : 1;
   localparam int SLICE_LOG = $clog2(SLICES);
   localparam int SLICE_AW  = (SLICE_LOG > 0) ? SLICE_LOG : 1;
   localparam int RND_W     = PROD_W + 1 - FRAC_SHIFT;
   localparam int CAL_MAX   = (1 << (CAL_W - 1)) - 1;
   localparam int CAL_MIN   = -(1 << (CAL_W - 1));
   localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

   req_type              req_ff;
   logic [THR_W-1:0]     thr_ff;
   logic [PIX_AW-1:0]    addr_ff;

   coef_type             coef_mem [PIXELS];
   coef_type             coef_rd_ff;
   logic [COEF_W-1:0]    ped_ff;
   logic [COEF_W-1:0]    gain_ff;
   logic                 hi_ff;

   logic [2*SAMPLE_W-1:0] buf_mem [SLICES];
   logic [2*SAMPLE_W-1:0] buf_rd_ff;

   logic                   v1_ff, v2_ff;
   logic [SLICE_NUM_W-1:0] k1_ff, k2_ff;
   logic                   last1_ff, last2_ff;

   logic [SAMPLE_W-1:0]      sample;
   logic signed [CAL_W-1:0]  diff;
   logic signed [CAL_W-1:0]  gain_s;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [PROD_W:0]   rsum;
   logic signed [RND_W-1:0]  rnd;
   logic signed [CAL_W-1:0]  sat;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   assign status.is_slice   = req_ff.mode == MODE_SLICE;
   assign status.is_last    = req_ff.last_slice;
   assign status.high_below = req_ff.high_sample < thr_ff;

   // Pixel index modulo PIXELS: two registered steps below the index range, else one register.
   if (PIXELS >= (1 << PIX_IN_W)) begin : g_direct
      always_ff @(posedge clock) begin
         addr_ff <= PIX_AW'(req_ff.pixel_index);
      end
   end else begin : g_reduce
      localparam int RED_SHIFT = PIX_IN_W + PIX_LOG;
      localparam int RED_RECIP = (1 << RED_SHIFT) / PIXELS;
      localparam int QP_W      = 2 * PIX_IN_W + 1;
      localparam int QD_W      = 2 * PIX_IN_W;

      logic [QP_W-1:0]     quot_prod;
      logic [PIX_IN_W-1:0] quot_ff;
      logic [QD_W-1:0]     quot_mul;
      logic [PIX_IN_W:0]   rem;
      logic [PIX_IN_W:0]   rem_fix;

      // estimate may come out one low; one correction covers it
      assign quot_prod = QP_W'(req_ff.pixel_index) * QP_W'(RED_RECIP);
      assign quot_mul  = QD_W'(quot_ff) * QD_W'(PIXELS);
      assign rem       = (PIX_IN_W + 1)'(req_ff.pixel_index) - (PIX_IN_W + 1)'(quot_mul);
      assign rem_fix   = (rem >= (PIX_IN_W + 1)'(PIXELS)) ?
                         rem - (PIX_IN_W + 1)'(PIXELS) : rem;

      always_ff @(posedge clock) begin
         quot_ff <= PIX_IN_W'(quot_prod >> RED_SHIFT);
         addr_ff <= PIX_AW'(rem_fix);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.coef_write) begin
         coef_mem[addr_ff] <= '{ped_high:  req_ff.ped_high,
                                ped_low:   req_ff.ped_low,
                                gain_high: req_ff.gain_high,
                                gain_low:  req_ff.gain_low};
      end
      if (cmd.coef_read) coef_rd_ff <= coef_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.coef_latch) begin
         hi_ff   <= cmd.use_high;
         ped_ff  <= cmd.use_high ? coef_rd_ff.ped_high  : coef_rd_ff.ped_low;
         gain_ff <= cmd.use_high ? coef_rd_ff.gain_high : coef_rd_ff.gain_low;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.buf_write) begin
         buf_mem[cmd.buf_index[SLICE_AW-1:0]] <= {req_ff.high_sample, req_ff.low_sample};
      end
      if (cmd.rd_valid) buf_rd_ff <= buf_mem[cmd.rd_index[SLICE_AW-1:0]];
   end

   assign sample  = hi_ff ? buf_rd_ff[2*SAMPLE_W-1:SAMPLE_W] : buf_rd_ff[SAMPLE_W-1:0];
   assign diff    = $signed({1'b0, sample, {PED_FRAC{1'b0}}}) - $signed({1'b0, ped_ff});
   assign gain_s  = $signed({1'b0, gain_ff});
   assign prod_in = PROD_W'(diff) * PROD_W'(gain_s);

   // round half up to Q.4, then clamp to the result range
   assign rsum = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(ROUND_HALF);
   assign rnd  = $signed(rsum[PROD_W:FRAC_SHIFT]);

   always_comb begin
      if (rnd > RND_W'(CAL_MAX)) begin
         sat = CAL_W'(CAL_MAX);
      end else if (rnd < RND_W'(CAL_MIN)) begin
         sat = CAL_W'(CAL_MIN);
      end else begin
         sat = rnd[CAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.rd_valid;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      k1_ff    <= cmd.rd_index;
      last1_ff <= cmd.rd_last;
      k2_ff    <= k1_ff;
      last2_ff <= last1_ff;
      prod_ff  <= prod_in;
      rsp_ff.calibrated_value <= sat;
      rsp_ff.used_high_gain   <= hi_ff;
      rsp_ff.slice_number     <= k2_ff;
      rsp_ff.last_result      <= last2_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/dgpc_checker.sv =====
// Checker for the dual-gain pixel calibrator: predicts every result word and compares it.
`timescale 1ns / 1ps
module dgpc_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  dgpc_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  dgpc_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [dgpc_pkg::THR_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending_count,
   output int                         result_count,
   output int                         pixel_count,
   output int                         high_pixel_count
);
   import dgpc_pkg::*;

   localparam int     SLICE_MAX  = SLICES_DEFAULT;
   localparam int     PIXEL_MAX  = PIXELS_DEFAULT;
   localparam int     REPORT_MAX = 40;
   localparam longint CAL_MAX    = (longint'(1) <<< (CAL_W - 1)) - 1;
   localparam longint CAL_MIN    = -(longint'(1) <<< (CAL_W - 1));

   coef_type            coef_mem [PIXEL_MAX];
   logic [SAMPLE_W-1:0] high_buf [SLICE_MAX];
   logic [SAMPLE_W-1:0] low_buf  [SLICE_MAX];
   int                  slices_held = 0;
   logic                all_below = 1'b1;
   logic [THR_W-1:0]    threshold = THR_RESET;
   rsp_type             cal_q [$];
   int                  errors = 0;
   int                  results_seen = 0;
   int                  pixels_done = 0;
   int                  high_pixels = 0;

   // (sample * 16 - pedestal) * gain, rounded half up from Q.20 to Q.4, saturated
   function automatic logic [CAL_W-1:0] scaled_sample(input logic [SAMPLE_W-1:0] sample,
                                                      input logic [COEF_W-1:0]   ped,
                                                      input logic [COEF_W-1:0]   gain);
      longint s, p, g, prod, q;
      s = sample;
      p = ped;
      g = gain;
      prod = (s * 16 - p) * g;
      q = (prod + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (q > CAL_MAX) q = CAL_MAX;
      else if (q < CAL_MIN) q = CAL_MIN;
      return q[CAL_W-1:0];
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (cal_q.size() == 0) begin
         errors++;
         if (errors <= REPORT_MAX)
            $display("%0t: unexpected result word, expected none, actual value %0d slice %0d",
                     $time, got.calibrated_value, got.slice_number);
      end else begin
         want = cal_q.pop_front();
         check_field("calibrated_value", want.calibrated_value, got.calibrated_value);
         check_field("used_high_gain", want.used_high_gain, got.used_high_gain);
         check_field("slice_number", want.slice_number, got.slice_number);
         check_field("last_result", want.last_result, got.last_result);
      end
   endtask

   task automatic absorb_word(input req_type w);
      coef_type            c;
      logic [COEF_W-1:0]   ped, gain;
      logic [SAMPLE_W-1:0] sample;
      rsp_type             r;
      logic                hi;
      int                  k;
      if (w.mode == MODE_LOAD) begin
         c.ped_high  = w.ped_high;
         c.ped_low   = w.ped_low;
         c.gain_high = w.gain_high;
         c.gain_low  = w.gain_low;
         coef_mem[w.pixel_index] = c;
      end else begin
         // drop slices beyond the buffer depth, they do not vote on the channel
         if (slices_held < SLICE_MAX) begin
            high_buf[slices_held] = w.high_sample;
            low_buf[slices_held]  = w.low_sample;
            if (!(w.high_sample < threshold)) all_below = 1'b0;
            slices_held++;
         end
         if (w.last_slice) begin
            hi   = all_below;
            c    = coef_mem[w.pixel_index];
            ped  = hi ? c.ped_high : c.ped_low;
            gain = hi ? c.gain_high : c.gain_low;
            for (k = 0; k < slices_held; k++) begin
               sample             = hi ? high_buf[k] : low_buf[k];
               r.calibrated_value = scaled_sample(sample, ped, gain);
               r.used_high_gain   = hi;
               r.slice_number     = k[SLICE_NUM_W-1:0];
               r.last_result      = (k == slices_held - 1);
               cal_q.push_back(r);
            end
            pixels_done++;
            if (hi) high_pixels++;
            slices_held = 0;
            all_below   = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slices_held = 0;
         all_below   = 1'b1;
         threshold   = THR_RESET;
         cal_q.delete();
      end else begin
         if (rsp_valid === 1'b1) check_result(rsp_data);
         if (csr_valid === 1'b1 && csr_ready === 1'b1) threshold = csr_data;
         if (start === 1'b1 && busy === 1'b0) absorb_word(req_data);
      end
      fail_count       <= errors;
      pending_count    <= cal_q.size();
      result_count     <= results_seen;
      pixel_count      <= pixels_done;
      high_pixel_count <= high_pixels;
   end

endmodule

// ===== tb/dual_gain_pixel_calibrator_tb.sv =====
// Testbench top for the dual-gain pixel calibrator: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module dual_gain_pixel_calibrator_tb;
   import dgpc_pkg::*;

   localparam int SLICE_MAX     = SLICES_DEFAULT;
   localparam int PIXEL_MAX     = PIXELS_DEFAULT;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
   localparam int COEF_MAX      = (1 << COEF_W) - 1;
   localparam int SETTLE_CYCLES = 2 * SLICE_MAX + 8;
   localparam int PHASES        = 6;
   localparam int PHASE_WORDS   = 58;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   req_type          req_data  = '0;
   logic             csr_valid = 1'b0;
   logic [THR_W-1:0] csr_data  = '0;
   logic             busy;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_ready;

   int fail_count, pending_count, result_count, pixel_count, high_pixel_count;

   int   phase_thr  [PHASES] = '{4095, 0, 0, 1, 2048, 4095};
   int   phase_idle [PHASES] = '{0, 61, 0, 11, 61, 0};
   int   idle_pct      = 0;
   int   threshold_now = 4095;
   int   words_sent    = 0;
   int   thr_writes    = 0;
   bit   loaded [PIXEL_MAX];
   int   loaded_list [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dual_gain_pixel_calibrator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   dgpc_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .result_count     (result_count),
      .pixel_count      (pixel_count),
      .high_pixel_count (high_pixel_count)
   );

   function automatic req_type noise_word();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(loaded_list.size() - 1, 0)];
   endfunction

   // start stays high after a word is taken, so a back-to-back word needs no toggle
   task automatic send_word(input req_type w);
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
   endtask

   // hold the sender until every result word is out and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(input int value);
      settle();
      csr_data  <= THR_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      threshold_now = value;
      thr_writes++;
   endtask

   task automatic load_pixel(input int idx, input int ph, input int pl, input int gh,
                             input int gl, input logic last);
      req_type w;
      w             = noise_word();
      w.mode        = MODE_LOAD;
      w.pixel_index = PIX_IN_W'(idx);
      w.last_slice  = last;
      w.ped_high    = COEF_W'(ph);
      w.ped_low     = COEF_W'(pl);
      w.gain_high   = COEF_W'(gh);
      w.gain_low    = COEF_W'(gl);
      send_word(w);
      if (!loaded[idx]) begin
         loaded[idx] = 1'b1;
         loaded_list.push_back(idx);
      end
   endtask

   task automatic send_slice(input int idx, input int hs, input int ls, input logic last);
      req_type w;
      w             = noise_word();
      w.mode        = MODE_SLICE;
      w.pixel_index = PIX_IN_W'(idx);
      w.high_sample = SAMPLE_W'(hs);
      w.low_sample  = SAMPLE_W'(ls);
      w.last_slice  = last;
      send_word(w);
   endtask

   task automatic random_load();
      int coef [4];
      int j;
      for (j = 0; j < 4; j++) begin
         case ($urandom_range(9, 0))
            0:       coef[j] = 0;
            1:       coef[j] = COEF_MAX;
            default: coef[j] = $urandom_range(COEF_MAX, 0);
         endcase
      end
      load_pixel($urandom_range(PIXEL_MAX - 1, 0), coef[0], coef[1], coef[2], coef[3],
                 1'($urandom_range(1, 0)));
   endtask

   task automatic random_pixel(input int slices_req);
      int   n, k, pick, hs;
      logic keep_below;
      if (slices_req > 0) n = slices_req;
      else begin
         pick = $urandom_range(99, 0);
         if (pick < 6) n = $urandom_range(SLICE_MAX + 4, SLICE_MAX + 1);
         else if (pick < 14) n = SLICE_MAX;
         else n = $urandom_range(8, 1);
      end
      keep_below = (threshold_now > 0) && ($urandom_range(1, 0) == 1);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(99, 0) < 10) random_load();
         // past the buffer depth, push a high sample that must not flip the channel
         if (keep_below) hs = (k < SLICE_MAX) ? $urandom_range(threshold_now - 1, 0) : SAMPLE_MAX;
         else if ($urandom_range(99, 0) < 15) hs = threshold_now;
         else hs = $urandom_range(SAMPLE_MAX, 0);
         send_slice(pick_loaded(), hs, $urandom_range(SAMPLE_MAX, 0), k == n - 1);
      end
   endtask

   initial begin
      int phase, phase_start, pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_threshold(4095);

      load_pixel(0, 0, 0, COEF_MAX, COEF_MAX, 1'b0);
      load_pixel(PIXEL_MAX - 1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
      load_pixel('h555, 'h1230, 'h0A00, 'h8000, 'h0001, 1'b0);
      load_pixel('h2AA, 0, 0, 0, 0, 1'b0);
      send_slice(0, 0, 0, 1'b1);
      send_slice(0, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
      send_slice(PIXEL_MAX - 1, 0, SAMPLE_MAX, 1'b1);
      send_slice(PIXEL_MAX - 1, SAMPLE_MAX - 1, 0, 1'b1);
      // coefficient write in the middle of a pixel; the last slice picks the pixel
      send_slice('h2AA, 100, 7, 1'b0);
      send_slice('h2AA, 200, 9, 1'b0);
      load_pixel('h2AA, COEF_MAX, 0, 'h0001, COEF_MAX, 1'b1);
      send_slice('h555, SAMPLE_MAX, 3000, 1'b1);
      send_slice('h2AA, 5, 6, 1'b1);
      set_threshold(0);
      send_slice(0, 0, 5, 1'b0);
      send_slice('h555, 0, 6, 1'b1);
      set_threshold(1);
      send_slice(0, 0, 100, 1'b1);
      send_slice(0, 1, 100, 1'b1);

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 2) phase_thr[phase] = $urandom_range(SAMPLE_MAX - 1, 2);
         set_threshold(phase_thr[phase]);
         idle_pct    = phase_idle[phase];
         phase_start = words_sent;
         random_pixel(SLICE_MAX + 2);
         while (words_sent - phase_start < PHASE_WORDS) begin
            pick = $urandom_range(99, 0);
            if (pick < 18) random_load();
            else if (pick < 22) settle();
            else random_pixel(0);
         end
      end

      settle();
      $display("%0d words sent over %0d threshold settings and idle rates of 0, 11 and 61 percent",
               words_sent, thr_writes);
      $display("%0d pixels calibrated (%0d on the high-gain channel), %0d result words checked",
               pixel_count, high_pixel_count, result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d result words still outstanding", pending_count);
      $display("simulation failed");
      $finish;
   end

endmodule
